// ----- rtl/scpd_pkg.sv -----
// Shared types for the sphere closest point / distance core.
// Used by the square root cells, the divider cells and the top level.
package scpd_pkg;

	typedef struct packed {
		logic vld;
		logic en;
	} scpd_ctl_t;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_MARGIN   = 3'd4
	} scpd_reg_t;

	typedef enum logic [1:0] {
		SEL_POINT  = 2'd0,
		SEL_CENTER = 2'd1,
		SEL_PROJ   = 2'd2
	} scpd_sel_t;

endpackage

// ----- rtl/scpd_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per stage.
// Depends on scpd_pkg for the control struct.
module scpd_sqrt_cell #(
	parameter int NR = 33,
	parameter int SW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scpd_pkg::scpd_ctl_t   ctl_i,
	input  logic [2*NR-1:0]       rad_i,
	input  logic [NR+1:0]         rem_i,
	input  logic [NR-1:0]         root_i,
	input  logic [SW-1:0]         side_i,
	output logic                  vld_o,
	output logic [2*NR-1:0]       rad_o,
	output logic [NR+1:0]         rem_o,
	output logic [NR-1:0]         root_o,
	output logic [SW-1:0]         side_o
);
	import scpd_pkg::*;

	logic [NR+1:0] t;
	logic [NR+1:0] trial;
	logic          ge;
	logic          vld_q;
	logic [2*NR-1:0] rad_q;
	logic [NR+1:0] rem_q;
	logic [NR-1:0] root_q;
	logic [SW-1:0] side_q;

	always_comb begin
		t     = {rem_i[NR-1:0], rad_i[2*NR-1 -: 2]};
		trial = {root_i, 2'b01};
		ge    = (t >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl_i.en) begin
			vld_q <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			rad_q  <= {rad_i[2*NR-3:0], 2'b00};
			rem_q  <= ge ? (t - trial) : t;
			root_q <= {root_i[NR-2:0], ge};
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign side_o = side_q;

endmodule

// ----- rtl/scpd_div_cell.sv -----
// One cell of the divider chain: one quotient bit per stage on three lanes.
// Depends on scpd_pkg for the control struct.
module scpd_div_cell #(
	parameter int W  = 32,
	parameter int SW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scpd_pkg::scpd_ctl_t  ctl_i,
	input  logic [W:0]           len_i,
	input  logic [W+1:0]         rem_i  [3],
	input  logic [W-2:0]         low_i  [3],
	input  logic [W-2:0]         quo_i  [3],
	input  logic [SW-1:0]        side_i,
	output logic                 vld_o,
	output logic [W:0]           len_o,
	output logic [W+1:0]         rem_o  [3],
	output logic [W-2:0]         low_o  [3],
	output logic [W-2:0]         quo_o  [3],
	output logic [SW-1:0]        side_o
);
	import scpd_pkg::*;

	logic [W+1:0] t   [3];
	logic         ge  [3];
	logic         vld_q;
	logic [W:0]   len_q;
	logic [W+1:0] rem_q [3];
	logic [W-2:0] low_q [3];
	logic [W-2:0] quo_q [3];
	logic [SW-1:0] side_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i]  = {rem_i[i][W:0], low_i[i][W-2]};
			ge[i] = (t[i] >= {1'b0, len_i});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl_i.en) begin
			vld_q <= ctl_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			len_q  <= len_i;
			side_q <= side_i;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge[i] ? (t[i] - {1'b0, len_i}) : t[i];
				low_q[i] <= low_i[i] << 1;
				quo_q[i] <= {quo_i[i][W-3:0], ge[i]};
			end
		end
	end

	assign vld_o  = vld_q;
	assign len_o  = len_q;
	assign rem_o  = rem_q;
	assign low_o  = low_q;
	assign quo_o  = quo_q;
	assign side_o = side_q;

endmodule

// ----- rtl/sphere_closest_point_distance_core.sv -----
// Top level of the point to sphere closest point and distance core.
// Uses scpd_pkg, scpd_sqrt_cell and scpd_div_cell.
//
// channel | signals                         | direction
// in      | in_valid, in_stall, point_*     | request in
// out     | out_valid, out_stall, closest_*,| request out
//         | surface_distance, is_inside     |
// cfg     | cfg_we, cfg_idx, cfg_data       | register write
//
// One request per cycle unless a stalled result holds the chain. A request passes
// the front, root cell chain (one bit per cell), numerator, divider chain, output.
// Reset clears the valid bits and the config registers to zero; data is not reset.
// A stalled result holds the whole chain; in_stall follows out_stall then.
module sphere_closest_point_distance_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] point_x,
	input  logic [COORD_WIDTH-1:0] point_y,
	input  logic [COORD_WIDTH-1:0] point_z,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COORD_WIDTH-1:0] closest_x,
	output logic [COORD_WIDTH-1:0] closest_y,
	output logic [COORD_WIDTH-1:0] closest_z,
	output logic [COORD_WIDTH-1:0] surface_distance,
	output logic                   is_inside,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_idx,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	import scpd_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int NR  = W + 1;
	localparam int SQS = 6 * W + 3;
	localparam int DVS = 4 * W + 6;
	localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};

	logic signed [W-1:0] cx_q, cy_q, cz_q, margin_q;
	logic        [W-2:0] rad_q;
	logic signed [W-1:0] cen [3];
	logic        [W-1:0] pin [3];

	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0; cy_q <= '0; cz_q <= '0; rad_q <= '0; margin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				REG_CENTER_Z: cz_q <= cfg_data;
				REG_RADIUS:   rad_q <= cfg_data[W-2:0];
				REG_MARGIN:   margin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cen[0] = cx_q;
	assign cen[1] = cy_q;
	assign cen[2] = cz_q;
	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// front: difference, square, sum
	logic              v_s1, v_s2, v_s3;
	logic [W-1:0]      p_s1 [3], p_s2 [3], p_s3 [3];
	logic signed [W:0] d_s1 [3], d_s2 [3], d_s3 [3];
	logic [2*W+1:0]    sq_s2 [3];
	logic [2*W+1:0]    sum_s3;
	logic [W:0]        m_s1 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_s1[i] = d_s1[i][W] ? (W+1)'(-d_s1[i]) : d_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]  <= pin[i];
				d_s1[i]  <= $signed({pin[i][W-1], pin[i]}) - $signed({cen[i][W-1], cen[i]});
				p_s2[i]  <= p_s1[i];
				d_s2[i]  <= d_s1[i];
				sq_s2[i] <= {{(W+1){1'b0}}, m_s1[i]} * {{(W+1){1'b0}}, m_s1[i]};
				p_s3[i]  <= p_s2[i];
				d_s3[i]  <= d_s2[i];
			end
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// square root chain
	logic              sv   [NR+1];
	logic [2*NR-1:0]   srad [NR+1];
	logic [NR+1:0]     srem [NR+1];
	logic [NR-1:0]     sroot[NR+1];
	logic [SQS-1:0]    sside[NR+1];

	assign sv[0]    = v_s3;
	assign srad[0]  = sum_s3;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sside[0] = {p_s3[0], p_s3[1], p_s3[2], d_s3[0], d_s3[1], d_s3[2]};

	for (genvar k = 0; k < NR; k++) begin : g_sqrt
		scpd_ctl_t c;
		assign c.vld = sv[k];
		assign c.en  = en;
		scpd_sqrt_cell #(.NR(NR), .SW(SQS)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl_i(c),
			.rad_i(srad[k]), .rem_i(srem[k]), .root_i(sroot[k]), .side_i(sside[k]),
			.vld_o(sv[k+1]), .rad_o(srad[k+1]), .rem_o(srem[k+1]),
			.root_o(sroot[k+1]), .side_o(sside[k+1])
		);
	end

	// post root: distance, selection, numerators
	logic [W-1:0]        pq [3];
	logic signed [W:0]   dq [3];
	logic [W:0]          mq [3];
	logic [W:0]          len;
	logic signed [W+1:0] sdiff;
	logic [W-1:0]        dsat;
	logic                insd;
	scpd_sel_t           sel;

	assign {pq[0], pq[1], pq[2], dq[0], dq[1], dq[2]} = sside[NR];
	assign len = sroot[NR];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mq[i] = dq[i][W] ? (W+1)'(-dq[i]) : dq[i];
		end
		sdiff = $signed({1'b0, len}) - $signed({3'b000, rad_q});
		dsat  = (sdiff > SMAX) ? SMAX[W-1:0] : sdiff[W-1:0];
		insd  = sdiff < $signed({{2{margin_q[W-1]}}, margin_q});
		if (len < {2'b00, rad_q}) begin
			sel = SEL_POINT;
		end else if (len == '0) begin
			sel = SEL_CENTER;
		end else begin
			sel = SEL_PROJ;
		end
	end

	logic           v_s4;
	logic [W:0]     len_s4;
	logic [2*W-1:0] num_s4 [3];
	logic [DVS-1:0] side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sv[NR];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s4  <= len;
			side_s4 <= {pq[0], pq[1], pq[2], dq[0][W], dq[1][W], dq[2][W], dsat, insd, sel};
			for (int i = 0; i < 3; i++) begin
				num_s4[i] <= (2*W)'({{(W-1){1'b0}}, mq[i]} * {{(W+2){1'b0}}, rad_q});
			end
		end
	end

	// divider chain
	localparam int ND = W - 1;
	logic           dv   [ND+1];
	logic [W:0]     dlen [ND+1];
	logic [W+1:0]   drem [ND+1][3];
	logic [W-2:0]   dlow [ND+1][3];
	logic [W-2:0]   dquo [ND+1][3];
	logic [DVS-1:0] dside[ND+1];

	assign dv[0]    = v_s4;
	assign dlen[0]  = len_s4;
	assign dside[0] = side_s4;
	for (genvar i = 0; i < 3; i++) begin : g_init
		assign drem[0][i] = {1'b0, num_s4[i][2*W-1:W-1]};
		assign dlow[0][i] = num_s4[i][W-2:0];
		assign dquo[0][i] = '0;
	end

	for (genvar k = 0; k < ND; k++) begin : g_div
		scpd_ctl_t c;
		assign c.vld = dv[k];
		assign c.en  = en;
		scpd_div_cell #(.W(W), .SW(DVS)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl_i(c), .len_i(dlen[k]),
			.rem_i(drem[k]), .low_i(dlow[k]), .quo_i(dquo[k]), .side_i(dside[k]),
			.vld_o(dv[k+1]), .len_o(dlen[k+1]), .rem_o(drem[k+1]),
			.low_o(dlow[k+1]), .quo_o(dquo[k+1]), .side_o(dside[k+1])
		);
	end

	// output stage
	logic [W-1:0]        fp [3];
	logic                fneg [3];
	logic [W-1:0]        fdist;
	logic                fin;
	scpd_sel_t           fsel;
	logic signed [W+1:0] sum [3];
	logic [W-1:0]        res [3];
	localparam logic signed [W+1:0] SMIN = -SMAX - 1;

	assign {fp[0], fp[1], fp[2], fneg[0], fneg[1], fneg[2], fdist, fin, fsel} = dside[ND];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = fneg[i]
				? $signed({{2{cen[i][W-1]}}, cen[i]}) - $signed({3'b000, dquo[ND][i]})
				: $signed({{2{cen[i][W-1]}}, cen[i]}) + $signed({3'b000, dquo[ND][i]});
			case (fsel)
				SEL_POINT:  res[i] = fp[i];
				SEL_CENTER: res[i] = cen[i];
				SEL_PROJ:   res[i] = (sum[i] > SMAX) ? SMAX[W-1:0] :
				                     (sum[i] < SMIN) ? SMIN[W-1:0] : sum[i][W-1:0];
				default:    res[i] = cen[i];
			endcase
		end
	end

	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			closest_x        <= res[0];
			closest_y        <= res[1];
			closest_z        <= res[2];
			surface_distance <= fdist;
			is_inside        <= fin;
		end
	end

	assign out_valid = out_valid_q;

	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_inside == ($signed(surface_distance) < margin_q))
		else $error("inside flag disagrees with distance");

	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rad_q == '0 |->
		closest_x == cx_q && closest_y == cy_q && closest_z == cz_q)
		else $error("zero radius must return the center");

endmodule
